[sv/ab_slot_record_checker_top_assert.svh]
// Assertion macros for the A/B slot record checker.
// Used by the port-level checker; no other dependencies.
`ifndef AB_SLOT_RECORD_CHECKER_TOP_ASSERT_SVH
`define AB_SLOT_RECORD_CHECKER_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ABS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("abs checker: same-cycle property failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ABS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("abs checker: next-cycle property failed");

`endif

[sv/abs_pkg.sv]
// Shared types, constants and CRC helper for the A/B slot record checker.
// No dependencies; used by the slot parser and the top level.
package abs_pkg;

  // Header layout
  localparam int unsigned HdrBytes    = 20;
  localparam int unsigned HdrCrcBytes = 16;
  localparam int unsigned HdrWords    = 5;

  // Header word positions
  localparam int unsigned FldMagic   = 0;
  localparam int unsigned FldGen     = 1;
  localparam int unsigned FldLength  = 2;
  localparam int unsigned FldPayCrc  = 3;
  localparam int unsigned FldHdrCrc  = 4;

  localparam logic [31:0] SlotMagic = 32'h5775_3102;
  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [1:0]  GenLast   = 2'd2;

  // Slot check outcome, presented on the end-of-slot beat
  typedef struct packed {
    logic        valid;
    logic [31:0] generation;
  } slot_status_t;

  // Currently chosen slot
  typedef struct packed {
    logic       exists;
    logic       slot;
    logic [1:0] generation;
  } choice_t;

  // One result beat
  typedef struct packed {
    logic        slot_valid;
    logic [31:0] slot_generation;
    logic        any_valid;
    logic        chosen_slot;
    logic [1:0]  chosen_generation;
  } result_t;

  // Reflected CRC-32, one byte per call
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Next generation modulo three
  function automatic logic [1:0] gen_after(input logic [1:0] g);
    return (g == GenLast) ? 2'd0 : g + 2'd1;
  endfunction

endpackage

[sv/abs_if.sv]
// Valid/ready channel interfaces for the A/B slot record checker.
// Input byte channel and result channel; no dependencies.
interface abs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       slot_sel;
  logic       end_of_slot;

  modport source (output valid, data_byte, slot_sel, end_of_slot, input ready);
  modport sink   (input valid, data_byte, slot_sel, end_of_slot, output ready);
endinterface

interface abs_out_if;
  logic        valid;
  logic        ready;
  logic        slot_valid;
  logic [31:0] slot_generation;
  logic        any_valid;
  logic        chosen_slot;
  logic [1:0]  chosen_generation;

  modport source (output valid, slot_valid, slot_generation, any_valid, chosen_slot,
                  chosen_generation, input ready);
  modport sink   (input valid, slot_valid, slot_generation, any_valid, chosen_slot,
                  chosen_generation, output ready);
endinterface

[sv/abs_slot_parser.sv]
// Per-slot header capture, running CRCs and validity check.
// Depends on abs_pkg for layout constants, CRC function and status type.
module abs_slot_parser #(
  parameter int unsigned SLOT_SIZE = 8192
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_slot_i,
  output abs_pkg::slot_status_t status_o
);

  localparam int unsigned PosW = $clog2(SLOT_SIZE + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(SLOT_SIZE);
  localparam logic [PosW-1:0] PosHdr = PosW'(abs_pkg::HdrBytes);
  localparam logic [PosW-1:0] PosCrc = PosW'(abs_pkg::HdrCrcBytes);
  localparam logic [31:0]     LenMax = 32'(SLOT_SIZE - abs_pkg::HdrBytes);

  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     hdr_q [abs_pkg::HdrWords];
  logic [31:0]     hdr_d [abs_pkg::HdrWords];
  logic [31:0]     crc_h_q, crc_h_d;
  logic [31:0]     crc_p_q, crc_p_d;
  logic            len_ok;
  logic            count_ok;

  // Capture header byte, advance CRCs and position for this beat
  always_comb begin
    hdr_d   = hdr_q;
    crc_h_d = crc_h_q;
    crc_p_d = crc_p_q;
    pos_d   = pos_q;
    if (pos_q < PosMax) begin
      if (pos_q < PosHdr) begin
        hdr_d[pos_q[4:2]][{pos_q[1:0], 3'b000} +: 8] = data_byte_i;
      end
      if (pos_q < PosCrc) begin
        crc_h_d = abs_pkg::crc32_byte(crc_h_q, data_byte_i);
      end
      if ((pos_q >= PosHdr) && (32'(pos_q - PosHdr) < hdr_q[abs_pkg::FldLength])) begin
        crc_p_d = abs_pkg::crc32_byte(crc_p_q, data_byte_i);
      end
      pos_d = pos_q + PosW'(1);
    end
  end

  // Judge the slot from the state after this beat
  assign len_ok   = (hdr_d[abs_pkg::FldLength] != 32'd0) &&
                    (hdr_d[abs_pkg::FldLength] <= LenMax);
  assign count_ok = 32'(pos_d) >= (32'(abs_pkg::HdrBytes) + hdr_d[abs_pkg::FldLength]);

  always_comb begin
    status_o.valid = (hdr_d[abs_pkg::FldMagic] == abs_pkg::SlotMagic) &&
                     (hdr_d[abs_pkg::FldGen] <= 32'(abs_pkg::GenLast)) &&
                     len_ok &&
                     ((crc_h_d ^ abs_pkg::CrcInit) == hdr_d[abs_pkg::FldHdrCrc]) &&
                     ((crc_p_d ^ abs_pkg::CrcInit) == hdr_d[abs_pkg::FldPayCrc]) &&
                     count_ok;
    status_o.generation = (pos_d >= PosHdr) ? hdr_d[abs_pkg::FldGen] : 32'd0;
  end

  // Hold position, header words and CRCs; restart them after the last beat of a slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hdr_q   <= '{default: '0};
      crc_h_q <= abs_pkg::CrcInit;
      crc_p_q <= abs_pkg::CrcInit;
    end else if (step_i) begin
      if (end_of_slot_i) begin
        pos_q   <= '0;
        hdr_q   <= '{default: '0};
        crc_h_q <= abs_pkg::CrcInit;
        crc_p_q <= abs_pkg::CrcInit;
      end else begin
        pos_q   <= pos_d;
        hdr_q   <= hdr_d;
        crc_h_q <= crc_h_d;
        crc_p_q <= crc_p_d;
      end
    end
  end

endmodule

[sv/ab_slot_record_checker_top.sv]
// A/B slot record checker: one image byte per beat, one result per slot end.
// The result beat is registered, in the main register or, while a result waits there, in the skid one.
// Throughput: one byte per cycle while ready is high; a byte-wide CRC update sets the cycle.
// A two-entry result buffer drops ready only while two results wait.
// Reset (async, active low) clears position, header, CRCs, choice and buffer flags.
module ab_slot_record_checker_top #(
  parameter int unsigned SLOT_SIZE = 8192
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  abs_in_if.sink    in_i,
  abs_out_if.source out_o
);

  logic                  accept;
  logic                  push;
  logic                  pop;
  abs_pkg::slot_status_t status;
  abs_pkg::choice_t      choice_q, choice_d;
  abs_pkg::result_t      result_d;
  abs_pkg::result_t      main_q, skid_q;
  logic                  main_valid_q, skid_valid_q;
  logic                  load_main_skid, load_main_new, load_skid;

  assign accept = in_i.valid && in_i.ready;
  assign push   = accept && in_i.end_of_slot;
  assign pop    = main_valid_q && out_o.ready;

  abs_slot_parser #(
    .SLOT_SIZE(SLOT_SIZE)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .data_byte_i  (in_i.data_byte),
    .end_of_slot_i(in_i.end_of_slot),
    .status_o     (status)
  );

  // Update the chosen slot at the end of a slot
  always_comb begin
    choice_d = choice_q;
    if (!in_i.slot_sel) begin
      choice_d.exists     = status.valid;
      choice_d.slot       = 1'b0;
      choice_d.generation = status.valid ? status.generation[1:0] : 2'd0;
    end else if (status.valid &&
                 (!choice_q.exists ||
                  (status.generation[1:0] == choice_q.generation) ||
                  (status.generation[1:0] == abs_pkg::gen_after(choice_q.generation)))) begin
      choice_d.exists     = 1'b1;
      choice_d.slot       = 1'b1;
      choice_d.generation = status.generation[1:0];
    end
  end

  always_comb begin
    result_d.slot_valid        = status.valid;
    result_d.slot_generation   = status.generation;
    result_d.any_valid         = choice_d.exists;
    result_d.chosen_slot       = choice_d.slot;
    result_d.chosen_generation = choice_d.generation;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      choice_q <= '0;
    end else if (push) begin
      choice_q <= choice_d;
    end
  end

  // Steer result beats through the main register and the skid register
  assign load_main_skid = skid_valid_q && pop;
  assign load_main_new  = !skid_valid_q && push && (!main_valid_q || pop);
  assign load_skid      = !skid_valid_q && push && main_valid_q && !pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (load_main_skid) begin
        skid_valid_q <= 1'b0;
      end else if (load_skid) begin
        skid_valid_q <= 1'b1;
      end
      if (load_main_new) begin
        main_valid_q <= 1'b1;
      end else if (pop && !skid_valid_q) begin
        main_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_main_skid) begin
      main_q <= skid_q;
    end else if (load_main_new) begin
      main_q <= result_d;
    end
    if (load_skid) begin
      skid_q <= result_d;
    end
  end

  // Drive the channels
  assign in_i.ready              = !skid_valid_q;
  assign out_o.valid             = main_valid_q;
  assign out_o.slot_valid        = main_q.slot_valid;
  assign out_o.slot_generation   = main_q.slot_generation;
  assign out_o.any_valid         = main_q.any_valid;
  assign out_o.chosen_slot       = main_q.chosen_slot;
  assign out_o.chosen_generation = main_q.chosen_generation;

endmodule

[sv/abs_checker.sv]
// Port-level assertions for the A/B slot record checker, bound to the top.
// Depends on ab_slot_record_checker_top_assert.svh for the assertion macros.
`include "ab_slot_record_checker_top_assert.svh"

module abs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_end_of_slot_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_slot_valid_i,
  input logic [31:0] out_slot_generation_i,
  input logic        out_any_valid_i,
  input logic        out_chosen_slot_i,
  input logic [1:0]  out_chosen_generation_i
);

  // A new result follows an accepted end-of-slot beat
  `ABS_ASSERT_SAME(a_rise_after_end, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i && in_end_of_slot_i))

  // A valid slot always leaves a choice and carries a legal generation
  `ABS_ASSERT_SAME(a_valid_implies_choice, clk_i, rst_ni, out_valid_i && out_slot_valid_i, out_any_valid_i && (out_slot_generation_i <= 32'd2))

  // Without a choice, slot and generation read as zero
  `ABS_ASSERT_SAME(a_no_choice_zero, clk_i, rst_ni, out_valid_i && !out_any_valid_i, !out_chosen_slot_i && (out_chosen_generation_i == 2'd0))

  // A stalled result holds its payload
  `ABS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_slot_valid_i) && $stable(out_slot_generation_i) && $stable(out_any_valid_i) && $stable(out_chosen_slot_i) && $stable(out_chosen_generation_i))

endmodule

bind ab_slot_record_checker_top abs_checker u_abs_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_valid_i             (in_i.valid),
  .in_ready_i             (in_i.ready),
  .in_end_of_slot_i       (in_i.end_of_slot),
  .out_valid_i            (out_o.valid),
  .out_ready_i            (out_o.ready),
  .out_slot_valid_i       (out_o.slot_valid),
  .out_slot_generation_i  (out_o.slot_generation),
  .out_any_valid_i        (out_o.any_valid),
  .out_chosen_slot_i      (out_o.chosen_slot),
  .out_chosen_generation_i(out_o.chosen_generation)
);
